### design/clb_pkg.sv
package clb_pkg;

    // Fixed field widths of the request and response beats
    localparam int CMD_W   = 2;
    localparam int CELL_W  = 12;
    localparam int CLASS_W = 4;
    localparam int COUNT_W = 13;

    // Request commands; any other code acts as a read
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_MOVE   = 2'd1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_PUSH,
        ST_CLEAR
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic unlink;
        logic push;
        logic clear;
        logic finish;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic insert_go;
        logic move_go;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [CLASS_W-1:0] old_class;
        logic               moved;
        logic [COUNT_W-1:0] class_count;
        logic [CELL_W-1:0]  head_cell;
        logic               head_valid;
        logic [CLASS_W-1:0] cell_class;
        logic [CELL_W-1:0]  next_cell;
        logic               next_valid;
        logic [CELL_W-1:0]  prev_cell;
        logic               prev_valid;
    } result_t;

endpackage

### design/clb_req_if.sv
interface clb_req_if import clb_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [CELL_W-1:0]  cell_req;
    logic [CLASS_W-1:0] new_class;

    modport source (output valid, cmd, cell_req, new_class, input ready);
    modport sink   (input valid, cmd, cell_req, new_class, output ready);

endinterface

### design/clb_rsp_if.sv
interface clb_rsp_if import clb_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] old_class;
    logic               moved;
    logic [COUNT_W-1:0] class_count;
    logic [CELL_W-1:0]  head_cell;
    logic               head_valid;
    logic [CLASS_W-1:0] cell_class;
    logic [CELL_W-1:0]  next_cell;
    logic               next_valid;
    logic [CELL_W-1:0]  prev_cell;
    logic               prev_valid;

    modport source (
        output valid, old_class, moved, class_count, head_cell, head_valid,
               cell_class, next_cell, next_valid, prev_cell, prev_valid,
        input  ready
    );
    modport sink (
        input  valid, old_class, moved, class_count, head_cell, head_valid,
               cell_class, next_cell, next_valid, prev_cell, prev_valid,
        output ready
    );

endinterface

### design/class_bucket_list_manager.sv
// Class bucket list manager: cells kept in per-class doubly linked lists.
// Request channel (req): cmd insert / move / read, cell_req, new_class.
// Response channel (rsp): one beat per request with the cell's old and new
// class, its links, and the head and member count of new_class.
// Both channels move a beat when valid and ready are high at a clock edge.
// Steps: a read, a move to the same class, or any out-of-range request
// has its response loaded at the end of the lookup step; an insert or a
// real move runs lookup (with unlink for a move), push, then clear own
// prev link. The next request is taken in the cycle after the response is
// loaded. The step count is set by the per-cell link stores: each has
// a single write port and a move writes the prev store up to three times.
// Reset empties all class heads and zeroes the counts at once; the cell
// stores are not cleared and a cell must be inserted before it is read.
// When rsp stalls the response register holds; a new request is still
// accepted and worked, and waits in its last step for the register.
module class_bucket_list_manager import clb_pkg::*; #(
    parameter int CELLS   = 4096,
    parameter int CLASSES = 16
) (
    input logic       clk,
    input logic       rst_n,
    clb_req_if.sink   req,
    clb_rsp_if.source rsp
);

    ctrl_t   ctrl;
    stat_t   stat;
    result_t result;
    logic    in_ready;
    logic    out_valid;

    clb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    clb_dpath #(
        .CELLS   (CELLS),
        .CLASSES (CLASSES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cmd       (req.cmd),
        .cell_req  (req.cell_req),
        .new_class (req.new_class),
        .out_ready (rsp.ready),
        .out_valid (out_valid),
        .result    (result)
    );

    assign req.ready       = in_ready;
    assign rsp.valid       = out_valid;
    assign rsp.old_class   = result.old_class;
    assign rsp.moved       = result.moved;
    assign rsp.class_count = result.class_count;
    assign rsp.head_cell   = result.head_cell;
    assign rsp.head_valid  = result.head_valid;
    assign rsp.cell_class  = result.cell_class;
    assign rsp.next_cell   = result.next_cell;
    assign rsp.next_valid  = result.next_valid;
    assign rsp.prev_cell   = result.prev_cell;
    assign rsp.prev_valid  = result.prev_valid;

endmodule

### design/clb_ctrl.sv
module clb_ctrl import clb_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   go;

    assign go = stat.insert_go | stat.move_go;

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through lookup, push and link clear
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (go)
                begin
                    state_next = ST_PUSH;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PUSH:
            begin
                state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        in_ready = 1'b0;
        ctrl     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.accept = in_valid;
            end
            ST_LOOK:
            begin
                ctrl.unlink = stat.move_go;
                ctrl.finish = !go && stat.out_free;
            end
            ST_PUSH:
            begin
                ctrl.push = 1'b1;
            end
            ST_CLEAR:
            begin
                ctrl.clear  = 1'b1;
                ctrl.finish = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### design/clb_dpath.sv
module clb_dpath import clb_pkg::*; #(
    parameter int CELLS   = 4096,
    parameter int CLASSES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    output stat_t              stat,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [CELL_W-1:0]  cell_req,
    input  logic [CLASS_W-1:0] new_class,
    input  logic               out_ready,
    output logic               out_valid,
    output result_t            result
);

    localparam int CW = $clog2(CELLS);
    localparam int KW = $clog2(CLASSES);
    localparam int LW = CW + 1;

    // Beat captured at accept
    cmd_t          cmd_reg;
    logic [CW-1:0] cell_reg;
    logic [KW-1:0] cls_reg;
    logic          cell_ok_reg;
    logic          cls_ok_reg;

    // Per-cell stores: class, next link, prev link (link MSB is valid)
    logic [KW-1:0] cls_mem [CELLS];
    logic [LW-1:0] nxt_mem [CELLS];
    logic [LW-1:0] prv_mem [CELLS];
    logic [KW-1:0] cls_rd_reg;
    logic [LW-1:0] nxt_rd_reg;
    logic [LW-1:0] prv_rd_reg;

    logic          nxt_we;
    logic [CW-1:0] nxt_wa;
    logic [LW-1:0] nxt_wd;
    logic          prv_we;
    logic [CW-1:0] prv_wa;
    logic [LW-1:0] prv_wd;

    // Per-class heads and counts
    logic [LW-1:0]      head_reg  [CLASSES];
    logic [COUNT_W-1:0] count_reg [CLASSES];
    logic [KW-1:0]      oc;
    logic [KW-1:0]      haddr;
    logic [LW-1:0]      sel_head;
    logic [COUNT_W-1:0] sel_cnt;
    logic [LW-1:0]      h_reg;

    logic    go;
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic [LW-1:0] nlink;
    logic [LW-1:0] plink;

    // Capture the request beat
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg     <= cmd_t'(cmd);
            cell_reg    <= CW'(cell_req);
            cls_reg     <= KW'(new_class);
            cell_ok_reg <= (32'(cell_req) < CELLS);
            cls_ok_reg  <= (32'(new_class) < CLASSES);
        end
    end

    // Read the cell entries at accept
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cls_rd_reg <= cls_mem[CW'(cell_req)];
            nxt_rd_reg <= nxt_mem[CW'(cell_req)];
            prv_rd_reg <= prv_mem[CW'(cell_req)];
        end
    end

    // Decode the item
    assign oc = (32'(cls_rd_reg) < CLASSES) ? cls_rd_reg : '0;
    assign stat.insert_go = cell_ok_reg && cls_ok_reg && (cmd_reg == CMD_INSERT);
    assign stat.move_go   = cell_ok_reg && cls_ok_reg && (cmd_reg == CMD_MOVE)
                            && (cls_rd_reg != cls_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign go = stat.insert_go | stat.move_go;

    // Select the class entry to read
    assign haddr    = ctrl.unlink ? oc : cls_reg;
    assign sel_head = head_reg[haddr];
    assign sel_cnt  = count_reg[haddr];

    // Steer link writes: unlink neighbors, push on head, clear own prev
    always_comb
    begin
        nxt_we = 1'b0;
        nxt_wa = cell_reg;
        nxt_wd = sel_head;
        prv_we = 1'b0;
        prv_wa = cell_reg;
        prv_wd = '0;
        if (ctrl.unlink)
        begin
            nxt_we = prv_rd_reg[CW];
            nxt_wa = prv_rd_reg[CW-1:0];
            nxt_wd = nxt_rd_reg;
            prv_we = nxt_rd_reg[CW];
            prv_wa = nxt_rd_reg[CW-1:0];
            prv_wd = prv_rd_reg;
        end
        else if (ctrl.push)
        begin
            nxt_we = 1'b1;
            prv_we = sel_head[CW];
            prv_wa = sel_head[CW-1:0];
            prv_wd = {1'b1, cell_reg};
        end
        else if (ctrl.clear)
        begin
            prv_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prv_we)
        begin
            prv_mem[prv_wa] <= prv_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            cls_mem[cell_reg] <= cls_reg;
        end
    end

    // Update heads and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLASSES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (ctrl.unlink)
        begin
            count_reg[oc] <= sel_cnt - COUNT_W'(1);
            if (!prv_rd_reg[CW])
            begin
                head_reg[oc] <= nxt_rd_reg;
            end
        end
        else if (ctrl.push)
        begin
            count_reg[cls_reg] <= sel_cnt + COUNT_W'(1);
            head_reg[cls_reg]  <= {1'b1, cell_reg};
        end
    end

    // Keep the old head; it becomes the cell's next link
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            h_reg <= sel_head;
        end
    end

    // Form the response beat
    assign nlink = go ? h_reg : nxt_rd_reg;
    assign plink = go ? '0 : prv_rd_reg;

    always_comb
    begin
        res_next = '0;
        if (cell_ok_reg)
        begin
            res_next.old_class  = stat.insert_go ? '0 : CLASS_W'(cls_rd_reg);
            res_next.moved      = go;
            res_next.cell_class = go ? CLASS_W'(cls_reg) : CLASS_W'(cls_rd_reg);
            res_next.next_valid = nlink[CW];
            res_next.next_cell  = nlink[CW] ? CELL_W'(nlink[CW-1:0]) : '0;
            res_next.prev_valid = plink[CW];
            res_next.prev_cell  = plink[CW] ? CELL_W'(plink[CW-1:0]) : '0;
        end
        if (cls_ok_reg)
        begin
            res_next.class_count = sel_cnt;
            res_next.head_valid  = sel_head[CW];
            res_next.head_cell   = sel_head[CW] ? CELL_W'(sel_head[CW-1:0]) : '0;
        end
    end

    // Hold the response until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule
